/* rtl/tse_pkg.sv */
package tse_pkg;

    localparam int DATA_W = 32;
    localparam int WORD_W = 2 * DATA_W + 1;

    localparam logic [1:0] OP_LSL_IMM  = 2'd0;
    localparam logic [1:0] OP_LSL_REG  = 2'd1;
    localparam logic [1:0] OP_LSR_IMM  = 2'd2;
    localparam logic [1:0] OP_SHIFT_32 = 2'd3;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_REG  = 2'd1;
    localparam logic [1:0] ERR_ROR_ZERO = 2'd2;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam logic [7:0] AMT_FULL = 8'd32;

    typedef struct packed {
        logic [3:0]        rd;
        logic [1:0]        kind;
        logic [5:0]        amt;
        logic              zero_amt;
        logic              kill;
        logic              fw;
        logic [1:0]        err;
        logic              cin;
        logic              vin;
        logic [DATA_W-1:0] src;
    } dec_t;

    typedef struct packed {
        logic [3:0]        rd;
        logic [1:0]        kind;
        logic [2:0]        fine;
        logic              zero_amt;
        logic              kill;
        logic              fw;
        logic [1:0]        err;
        logic              cin;
        logic              vin;
        logic [WORD_W-1:0] word;
    } crs_t;

    typedef struct packed {
        logic [3:0]        rd;
        logic [DATA_W-1:0] res;
        logic              c;
        logic              fw;
        logic [1:0]        err;
        logic              vin;
    } shf_t;

    function automatic logic [DATA_W-1:0] rev32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++)
        begin
            r[i] = v[DATA_W-1-i];
        end
        return r;
    endfunction

endpackage

/* rtl/tse_decode.sv */
module tse_decode
    import tse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  op,
    input  logic [31:0] instruction,
    input  logic        in_it_block,
    input  logic [31:0] source_value,
    input  logic [7:0]  amount_value,
    input  logic        carry_in,
    input  logic        overflow_in,
    output logic        dec_valid,
    output dec_t        dec
);

    logic       dec_valid_reg;
    dec_t       dec_reg;
    dec_t       dec_next;
    logic [4:0] imm5_16;
    logic [4:0] imm5_32;
    logic [3:0] rm_32;
    logic [7:0] n;

    assign imm5_16 = instruction[10:6];
    assign imm5_32 = {instruction[14:12], instruction[7:6]};
    assign rm_32   = instruction[3:0];

    always_comb
    begin
        dec_next     = '0;
        n            = '0;
        dec_next.cin = carry_in;
        dec_next.vin = overflow_in;
        dec_next.src = source_value;
        unique case (op)
            OP_LSL_IMM:
            begin
                dec_next.rd   = {1'b0, instruction[2:0]};
                dec_next.kind = SH_LSL;
                dec_next.fw   = ~in_it_block;
                n             = {3'b000, imm5_16};
            end
            OP_LSL_REG:
            begin
                dec_next.rd   = {1'b0, instruction[2:0]};
                dec_next.kind = SH_LSL;
                dec_next.fw   = ~in_it_block;
                n             = amount_value;
            end
            OP_LSR_IMM:
            begin
                dec_next.rd   = {1'b0, instruction[2:0]};
                dec_next.kind = SH_LSR;
                dec_next.fw   = ~in_it_block;
                n             = (imm5_16 == 5'd0) ? AMT_FULL : {3'b000, imm5_16};
            end
            OP_SHIFT_32:
            begin
                dec_next.rd   = instruction[11:8];
                dec_next.kind = instruction[5:4];
                dec_next.fw   = instruction[20];
                n             = {3'b000, imm5_32};
                if ((instruction[5:4] == SH_LSR || instruction[5:4] == SH_ASR)
                    && imm5_32 == 5'd0)
                begin
                    n = AMT_FULL;
                end
                if (instruction[11:8] == REG_SP || instruction[11:8] == REG_PC
                    || rm_32 == REG_SP || rm_32 == REG_PC)
                begin
                    dec_next.err = ERR_BAD_REG;
                end
                else if (instruction[5:4] == SH_ROR && imm5_32 == 5'd0)
                begin
                    dec_next.err = ERR_ROR_ZERO;
                end
            end
            default:
            begin
                dec_next.rd = '0;
            end
        endcase
        dec_next.amt      = n[5:0];
        dec_next.zero_amt = (n == 8'd0);
        dec_next.kill     = (n > AMT_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else
        begin
            dec_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec_valid = dec_valid_reg;
    assign dec       = dec_reg;

endmodule

/* rtl/tse_shifter.sv */
module tse_shifter
    import tse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic dec_valid,
    input  dec_t dec,
    output logic sh_valid,
    output shf_t sh
);

    // Right shift of {fill, operand, guard}; LSL runs on the bit-reversed operand.
    logic              crs_valid_reg;
    crs_t              crs_reg;
    crs_t              crs_next;
    logic              shf_valid_reg;
    shf_t              shf_reg;
    shf_t              shf_next;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [WORD_W-1:0] wide;
    logic [WORD_W-1:0] fine_word;
    logic [DATA_W-1:0] raw;

    always_comb
    begin
        unique case (dec.kind)
            SH_LSL:  hi = '0;
            SH_LSR:  hi = '0;
            SH_ASR:  hi = {DATA_W{dec.src[DATA_W-1]}};
            SH_ROR:  hi = dec.src;
            default: hi = '0;
        endcase
        lo   = (dec.kind == SH_LSL) ? rev32(dec.src) : dec.src;
        wide = {hi, lo, 1'b0};

        crs_next          = '0;
        crs_next.rd       = dec.rd;
        crs_next.kind     = dec.kind;
        crs_next.fine     = dec.amt[2:0];
        crs_next.zero_amt = dec.zero_amt;
        crs_next.kill     = dec.kill;
        crs_next.fw       = dec.fw;
        crs_next.err      = dec.err;
        crs_next.cin      = dec.cin;
        crs_next.vin      = dec.vin;
        crs_next.word     = wide >> {dec.amt[5:3], 3'b000};
    end

    always_comb
    begin
        fine_word    = crs_reg.word >> crs_reg.fine;
        raw          = fine_word[DATA_W:1];
        shf_next     = '0;
        shf_next.rd  = crs_reg.rd;
        shf_next.fw  = crs_reg.fw;
        shf_next.err = crs_reg.err;
        shf_next.vin = crs_reg.vin;
        priority if (crs_reg.err != ERR_NONE || crs_reg.kill)
        begin
            shf_next.res = '0;
            shf_next.c   = 1'b0;
        end
        else if (crs_reg.zero_amt)
        begin
            shf_next.res = (crs_reg.kind == SH_LSL) ? rev32(raw) : raw;
            shf_next.c   = crs_reg.cin;
        end
        else
        begin
            shf_next.res = (crs_reg.kind == SH_LSL) ? rev32(raw) : raw;
            shf_next.c   = fine_word[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crs_valid_reg <= 1'b0;
            shf_valid_reg <= 1'b0;
        end
        else
        begin
            crs_valid_reg <= dec_valid;
            shf_valid_reg <= crs_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_valid)
        begin
            crs_reg <= crs_next;
        end
        if (crs_valid_reg)
        begin
            shf_reg <= shf_next;
        end
    end

    assign sh_valid = shf_valid_reg;
    assign sh       = shf_reg;

endmodule

/* rtl/tse_flags.sv */
module tse_flags
    import tse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sh_valid,
    input  shf_t        sh,
    output logic        done,
    output logic [3:0]  dest_reg,
    output logic [31:0] result,
    output logic        reg_write,
    output logic        flags_write,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_c,
    output logic        flag_v,
    output logic [1:0]  error
);

    logic        done_reg;
    logic [3:0]  dest_reg_reg;
    logic [31:0] result_reg;
    logic        reg_write_reg;
    logic        flags_write_reg;
    logic        flag_n_reg;
    logic        flag_z_reg;
    logic        flag_c_reg;
    logic        flag_v_reg;
    logic [1:0]  error_reg;
    logic        ok;

    assign ok = (sh.err == ERR_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sh_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sh_valid)
        begin
            dest_reg_reg    <= sh.rd;
            result_reg      <= sh.res;
            reg_write_reg   <= ok;
            flags_write_reg <= ok & sh.fw;
            flag_n_reg      <= ok & sh.res[DATA_W-1];
            flag_z_reg      <= ok & (sh.res == '0);
            flag_c_reg      <= ok & sh.c;
            flag_v_reg      <= sh.vin;
            error_reg       <= sh.err;
        end
    end

    assign done        = done_reg;
    assign dest_reg    = dest_reg_reg;
    assign result      = result_reg;
    assign reg_write   = reg_write_reg;
    assign flags_write = flags_write_reg;
    assign flag_n      = flag_n_reg;
    assign flag_z      = flag_z_reg;
    assign flag_c      = flag_c_reg;
    assign flag_v      = flag_v_reg;
    assign error       = error_reg;

endmodule

/* rtl/thumb_shift_execute.sv */
// Channel   Handshake          Fields
// ------    ---------          ------
// item in   start / busy       op, instruction, in_it_block, source_value,
//                              amount_value, carry_in, overflow_in
// result    done (one cycle)   dest_reg, result, reg_write, flags_write,
//                              flag_n, flag_z, flag_c, flag_v, error
//
// One item per cycle; each result is registered in every stage below before it appears on done.
// Stages: decode, coarse shift (multiples of 8), fine shift with carry, flags.
// busy is always low: nothing in the pipe ever stalls.
// rst_n clears the stage valid bits asynchronously; payload is not reset.
module thumb_shift_execute
    import tse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] instruction,
    input  logic        in_it_block,
    input  logic [31:0] source_value,
    input  logic [7:0]  amount_value,
    input  logic        carry_in,
    input  logic        overflow_in,
    output logic        done,
    output logic [3:0]  dest_reg,
    output logic [31:0] result,
    output logic        reg_write,
    output logic        flags_write,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_c,
    output logic        flag_v,
    output logic [1:0]  error
);

    logic dec_valid;
    dec_t dec;
    logic sh_valid;
    shf_t sh;

    assign busy = 1'b0;

    tse_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start & ~busy),
        .op           (op),
        .instruction  (instruction),
        .in_it_block  (in_it_block),
        .source_value (source_value),
        .amount_value (amount_value),
        .carry_in     (carry_in),
        .overflow_in  (overflow_in),
        .dec_valid    (dec_valid),
        .dec          (dec)
    );

    tse_shifter u_shifter (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .sh_valid  (sh_valid),
        .sh        (sh)
    );

    tse_flags u_flags (
        .clk         (clk),
        .rst_n       (rst_n),
        .sh_valid    (sh_valid),
        .sh          (sh),
        .done        (done),
        .dest_reg    (dest_reg),
        .result      (result),
        .reg_write   (reg_write),
        .flags_write (flags_write),
        .flag_n      (flag_n),
        .flag_z      (flag_z),
        .flag_c      (flag_c),
        .flag_v      (flag_v),
        .error       (error)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("item did not complete after four cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without a matching item");

    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error != ERR_NONE) |->
            (!reg_write && !flags_write && result == '0 && !flag_c))
        else $error("errored item writes state");

    a_ok_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error == ERR_NONE) |-> (reg_write && flag_z == (result == '0)))
        else $error("good item lost its write or zero flag");

endmodule
